@@ rtl/lmsln_pkg.sv @@
// Shared types and constants for the LMS linear neuron trainer.
// Used by the weight bank, the shared multiplier and the top level.
package lmsln_pkg;

	// number of features per item and widths of the stored values
	localparam int NUM_FEATURES = 9;
	localparam int IDX_W        = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
	localparam int FEAT_W       = 16;
	localparam int WEIGHT_W     = 32;

	// shared multiplier operand and product widths
	localparam int MUL_A_W = 48;
	localparam int MUL_B_W = 25;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// weight reset value: 0.5 in Q16.16
	localparam logic signed [WEIGHT_W-1:0] WEIGHT_RESET = 32'sd32768;

	typedef logic [IDX_W-1:0]           idx_t;
	typedef logic signed [WEIGHT_W-1:0] weight_t;

	// write request into the weight bank
	typedef struct packed {
		logic    we;
		idx_t    addr;
		weight_t data;
	} wr_req_t;

endpackage

@@ rtl/lmsln_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on lmsln_pkg for the operand and product widths.
module lmsln_mul (
	input  logic                                   clk,
	input  logic signed [lmsln_pkg::MUL_A_W-1:0]   op_a,
	input  logic signed [lmsln_pkg::MUL_B_W-1:0]   op_b,
	output logic signed [lmsln_pkg::PROD_W-1:0]    prod
);

	logic signed [lmsln_pkg::PROD_W-1:0] prod_q;

	// register the product every cycle
	always_ff @(posedge clk) begin
		prod_q <= lmsln_pkg::PROD_W'(op_a) * lmsln_pkg::PROD_W'(op_b);
	end

	assign prod = prod_q;

endmodule

@@ rtl/lmsln_wbank.sv @@
// Weight bank: one register per feature, reset to 0.5, one read and one write port.
// Depends on lmsln_pkg for the index, weight and write request types.
module lmsln_wbank (
	input  logic                clk,
	input  logic                arst_n,
	input  lmsln_pkg::wr_req_t  wr,
	input  lmsln_pkg::idx_t     raddr,
	output lmsln_pkg::weight_t  rdata
);

	lmsln_pkg::weight_t weight_q [lmsln_pkg::NUM_FEATURES];

	// load reset weights, then take one write per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lmsln_pkg::NUM_FEATURES; i++) begin
				weight_q[i] <= lmsln_pkg::WEIGHT_RESET;
			end
		end else if (wr.we) begin
			weight_q[wr.addr] <= wr.data;
		end
	end

	assign rdata = weight_q[raddr];

endmodule

@@ rtl/lms_linear_neuron_trainer_unit.sv @@
// Top level of the LMS linear neuron trainer: sequencer and datapath around one
// shared multiplier. Depends on lmsln_pkg, lmsln_mul and lmsln_wbank.
// Channels:
//   Item (item_valid / item_stall) takes req_type, feature_0..feature_8 and target;
//   a beat is taken when item_valid is high and item_stall low.
//   Result (result_valid / result_stall) returns one prediction beat per item: the
//   dot product of the features with the weights held before the item, rounded
//   and saturated to Q16.16.
//   Config (cfg_valid / cfg_ready) writes learn_rate; cfg_ready is always high.
//   Write it only while the block is idle.
// Timing:
//   One product per cycle. A predict item runs 9 products plus pipeline fill, then
//   rounding, then returns to idle; the prediction is registered at rounding.
//   A train item adds the error scaling (error, then scale) and 9 weight updates.
//   item_stall is high until the sequencer is idle.
// Reset: arst_n clears the sequencer and result valid, sets every weight to 0.5
//   and learn_rate to 16777 (about 0.001).
// Result stall: the prediction waits in an output register; while it is still full
//   the next prediction holds the sequencer at rounding until result_stall drops.
module lms_linear_neuron_trainer_unit (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [23:0]        learn_rate,
	// item channel
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               req_type,
	input  logic signed [15:0] feature_0,
	input  logic signed [15:0] feature_1,
	input  logic signed [15:0] feature_2,
	input  logic signed [15:0] feature_3,
	input  logic signed [15:0] feature_4,
	input  logic signed [15:0] feature_5,
	input  logic signed [15:0] feature_6,
	input  logic signed [15:0] feature_7,
	input  logic signed [15:0] feature_8,
	input  logic signed [15:0] target,
	// result channel
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] prediction
);

	localparam int NF       = lmsln_pkg::NUM_FEATURES;
	localparam int IDX_W    = lmsln_pkg::IDX_W;
	localparam int FEAT_W   = lmsln_pkg::FEAT_W;
	localparam int WEIGHT_W = lmsln_pkg::WEIGHT_W;
	localparam int MUL_A_W  = lmsln_pkg::MUL_A_W;
	localparam int MUL_B_W  = lmsln_pkg::MUL_B_W;
	localparam int PROD_W   = lmsln_pkg::PROD_W;
	localparam int CNT_W    = $clog2(NF + 1);
	localparam int LR_W     = 24;

	// accumulator and rounding widths
	localparam int ACC_W     = FEAT_W + WEIGHT_W + CNT_W;
	localparam int PRED_SH   = 14;
	localparam int PRED_RW   = ACC_W - PRED_SH;
	localparam int ERR_W     = WEIGHT_W + 2;
	localparam int SCL_SH    = 10;
	localparam int SCL_SRC_W = 60;
	localparam int STEP_SH   = 28;
	localparam int STEP_SRC_W = 64;
	localparam int STEP_W    = STEP_SRC_W - STEP_SH;
	localparam int NEW_W     = STEP_W + 1;

	localparam logic [LR_W-1:0] LR_RESET = 24'd16777;
	localparam logic signed [WEIGHT_W-1:0] W_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
	localparam logic signed [WEIGHT_W-1:0] W_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MAC  = 3'd1;
	localparam logic [2:0] ST_RND  = 3'd2;
	localparam logic [2:0] ST_ERR  = 3'd3;
	localparam logic [2:0] ST_SCL  = 3'd4;
	localparam logic [2:0] ST_UPD  = 3'd5;

	logic [2:0]                  state_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [LR_W-1:0]             lr_q;
	logic                        res_valid_q;
	logic signed [WEIGHT_W-1:0]  prediction_q;

	logic signed [FEAT_W-1:0]    feat_q [NF];
	logic signed [FEAT_W-1:0]    tgt_q;
	logic                        req_q;
	logic signed [ACC_W-1:0]     acc_q;
	logic signed [WEIGHT_W-1:0]  pred_q;
	logic signed [MUL_A_W-1:0]   scaled_q;
	lmsln_pkg::weight_t          wold_q;
	lmsln_pkg::idx_t             widx_q;

	logic                        accept;
	logic                        cnt_last;
	logic                        out_free;
	lmsln_pkg::idx_t             rd_idx;
	lmsln_pkg::weight_t          w_rd;
	logic signed [FEAT_W-1:0]    feat_rd;
	logic signed [MUL_A_W-1:0]   op_a;
	logic signed [MUL_B_W-1:0]   op_b;
	logic signed [PROD_W-1:0]    prod;
	logic signed [ACC_W-1:0]     pred_sum;
	logic signed [PRED_RW-1:0]   pred_rnd;
	logic signed [WEIGHT_W-1:0]  pred_sat;
	logic signed [ERR_W-1:0]     err;
	logic signed [SCL_SRC_W-1:0] scl_sum;
	logic signed [STEP_SRC_W-1:0] step_sum;
	logic signed [STEP_W-1:0]    step;
	logic signed [NEW_W-1:0]     w_new;
	logic signed [WEIGHT_W-1:0]  w_sat;
	lmsln_pkg::wr_req_t          wr;

	assign cfg_ready    = 1'b1;
	assign item_stall   = (state_q != ST_IDLE);
	assign accept       = item_valid && !item_stall;
	assign result_valid = res_valid_q;
	assign prediction   = prediction_q;
	assign cnt_last     = (cnt_q == CNT_W'(NF));
	assign out_free     = !res_valid_q || !result_stall;

	// select the element for this cycle; park at zero past the last one
	assign rd_idx  = cnt_last ? '0 : cnt_q[IDX_W-1:0];
	assign feat_rd = feat_q[rd_idx];

	// steer the shared multiplier
	always_comb begin
		case (state_q)
			ST_ERR: begin
				op_a = {{(MUL_A_W-ERR_W){err[ERR_W-1]}}, err};
				op_b = {1'b0, lr_q};
			end
			ST_UPD: begin
				op_a = scaled_q;
				op_b = {{(MUL_B_W-FEAT_W){feat_rd[FEAT_W-1]}}, feat_rd};
			end
			default: begin
				op_a = {{(MUL_A_W-WEIGHT_W){w_rd[WEIGHT_W-1]}}, w_rd};
				op_b = {{(MUL_B_W-FEAT_W){feat_rd[FEAT_W-1]}}, feat_rd};
			end
		endcase
	end

	lmsln_mul u_mul (
		.clk  (clk),
		.op_a (op_a),
		.op_b (op_b),
		.prod (prod)
	);

	// round the dot product to Q16.16 and saturate
	always_comb begin
		pred_sum = acc_q + ACC_W'(1 << (PRED_SH - 1));
		pred_rnd = pred_sum[ACC_W-1:PRED_SH];
		if (pred_rnd[PRED_RW-1:WEIGHT_W-1] == {(PRED_RW-WEIGHT_W+1){pred_rnd[WEIGHT_W-1]}}) begin
			pred_sat = pred_rnd[WEIGHT_W-1:0];
		end else begin
			pred_sat = pred_rnd[PRED_RW-1] ? W_MIN : W_MAX;
		end
	end

	// error against the target lifted to Q16.16
	assign err = {{2{pred_q[WEIGHT_W-1]}}, pred_q}
		- {{(ERR_W-FEAT_W-2){tgt_q[FEAT_W-1]}}, tgt_q, 2'b00};

	// round learn rate times error down to Q16.30
	assign scl_sum = prod[SCL_SRC_W-1:0] + SCL_SRC_W'(1 << (SCL_SH - 1));

	// round the weight step to Q16.16, subtract and saturate
	always_comb begin
		step_sum = prod[STEP_SRC_W-1:0] + STEP_SRC_W'(1 << (STEP_SH - 1));
		step     = step_sum[STEP_SRC_W-1:STEP_SH];
		w_new    = {{(NEW_W-WEIGHT_W){wold_q[WEIGHT_W-1]}}, wold_q}
			- {step[STEP_W-1], step};
		if (w_new[NEW_W-1:WEIGHT_W-1] == {(NEW_W-WEIGHT_W+1){w_new[WEIGHT_W-1]}}) begin
			w_sat = w_new[WEIGHT_W-1:0];
		end else begin
			w_sat = w_new[NEW_W-1] ? W_MIN : W_MAX;
		end
	end

	// write back the weight whose product came out this cycle
	assign wr.we   = (state_q == ST_UPD) && (cnt_q != '0);
	assign wr.addr = widx_q;
	assign wr.data = w_sat;

	lmsln_wbank u_wbank (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.raddr  (rd_idx),
		.rdata  (w_rd)
	);

	// sequencer, learning rate and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			lr_q        <= LR_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				lr_q <= learn_rate;
			end
			// raise valid when rounding hands off a beat, drop it once taken
			if (state_q == ST_RND && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MAC;
						cnt_q   <= '0;
					end
				end
				ST_MAC: begin
					if (cnt_last) begin
						state_q <= ST_RND;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_RND: begin
					// hold until the output register can take the beat
					if (out_free) begin
						state_q <= req_q ? ST_ERR : ST_IDLE;
					end
				end
				ST_ERR: begin
					state_q <= ST_SCL;
				end
				ST_SCL: begin
					state_q <= ST_UPD;
					cnt_q   <= '0;
				end
				ST_UPD: begin
					if (cnt_last) begin
						state_q <= ST_IDLE;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			feat_q[0] <= feature_0;
			feat_q[1] <= feature_1;
			feat_q[2] <= feature_2;
			feat_q[3] <= feature_3;
			feat_q[4] <= feature_4;
			feat_q[5] <= feature_5;
			feat_q[6] <= feature_6;
			feat_q[7] <= feature_7;
			feat_q[8] <= feature_8;
			tgt_q     <= target;
			req_q     <= req_type;
			acc_q     <= '0;
		end
		// accumulate the product issued in the previous cycle
		if (state_q == ST_MAC && cnt_q != '0) begin
			acc_q <= acc_q + prod[ACC_W-1:0];
		end
		if (state_q == ST_RND) begin
			pred_q <= pred_sat;
			if (out_free) begin
				prediction_q <= pred_sat;
			end
		end
		if (state_q == ST_SCL) begin
			scaled_q <= scl_sum[MUL_A_W+SCL_SH-1:SCL_SH];
		end
		// keep the old weight and its index beside the product in flight
		if (state_q == ST_UPD) begin
			wold_q <= w_rd;
			widx_q <= rd_idx;
		end
	end

endmodule
